// ----- src/rcsc_pkg.sv -----
// rcsc_pkg: shared constants, field widths and the front-to-back command word
// for the read correction score counter; no dependencies
package rcsc_pkg;

	// counter widths
	localparam int TOTAL_W = 32;
	localparam int READ_W = 16;
	localparam int SUM_W = ((TOTAL_W > READ_W + 1) ? TOTAL_W : READ_W + 1) + 1;

	// ascii codes that steer the classification
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_GAP = 8'h2D;

	// per-read delta slots
	localparam int D_TP = 0;
	localparam int D_TN = 1;
	localparam int D_FP = 2;
	localparam int D_FN = 3;
	localparam int D_INIT_N = 4;
	localparam int D_NEW_N = 5;
	localparam int D_INIT_ERR = 6;
	localparam int D_REM_ERR = 7;
	localparam int NUM_DELTA = 8;
	localparam int NUM_INC = 6;

	// whole-read recovery classes
	localparam logic [1:0] FULL_TP = 2'd0;
	localparam logic [1:0] FULL_TN = 2'd1;
	localparam logic [1:0] FULL_FP = 2'd2;
	localparam logic [1:0] FULL_FN = 2'd3;

	// command queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// stream word widths
	localparam int IN_W = 32;
	localparam int OUT_W = 11 * 32 + 16;

	// one classified word from the front to the back
	typedef struct packed {
		logic [NUM_INC-1:0][READ_W:0] inc;
		logic close;
		logic aligned;
		logic [READ_W-1:0] init_err;
		logic rem_zero;
	} cmd_t;

endpackage

// ----- src/read_correction_score_counter.sv -----
// read_correction_score_counter: top level, front classifier, command queue
// and totals back end; depends on rcsc_pkg, rcsc_front, rcsc_queue, rcsc_back
//
// Scores read correction one aligned column per input word (corrected,
// uncorrected and true base) and emits a word with all twelve saturating
// totals when a read closes (tlast, or tuser set for an empty read). Input
// words are taken at one per cycle while the queue has room; the front keeps
// the per-read state (gap deltas, error counts) and the back applies each
// word to the totals, so the sustained rate is one word per cycle unless a
// stalled result word holds back a closing word. A result word passes from
// the queue into the output register before it shows on m_tvalid; a
// four-word queue between front and back absorbs stalls on the output side.
module read_correction_score_counter import rcsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// corrected_base, erroneous_base, true_base, read_aligned, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	// no_column
	input  logic             s_tuser,
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	// total_tp, total_tn, total_fp, total_fn, compared_reads, initial_n_count,
	// new_n_count, max_read_errors, full_tp, full_tn, full_fp, full_fn
	output logic [OUT_W-1:0] m_tdata
);

	logic push;
	logic pop;
	logic q_full;
	logic q_valid;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	// column classification
	rcsc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.corrected_base (s_tdata[7:0]),
		.erroneous_base (s_tdata[15:8]),
		.true_base      (s_tdata[23:16]),
		.no_column      (s_tuser),
		.last_column    (s_tlast),
		.read_aligned   (s_tdata[24]),
		.q_full         (q_full),
		.push           (push),
		.cmd            (push_cmd)
	);

	// decoupling queue
	rcsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.valid    (q_valid)
	);

	// totals and result word
	rcsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.cmd      (pop_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- src/rcsc_front.sv -----
// rcsc_front: accepts column words, classifies them and tracks per-read state
// (gap deltas, error counts); depends on rcsc_pkg
module rcsc_front import rcsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] corrected_base,
	input  logic [7:0] erroneous_base,
	input  logic [7:0] true_base,
	input  logic       no_column,
	input  logic       last_column,
	input  logic       read_aligned,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	localparam logic [READ_W-1:0] READ_MAX = {READ_W{1'b1}};

	logic [NUM_DELTA-1:0][READ_W-1:0] pend_q, pend_n;
	logic [1:0][READ_W-1:0] err_q, err_n, err_upd;
	logic started_q, started_n;
	logic [NUM_DELTA-1:0] delta;
	logic gap;
	logic close;

	// per-column delta vector
	function automatic logic [NUM_DELTA-1:0] classify(logic [7:0] c, logic [7:0] e,
			logic [7:0] t);
		logic [NUM_DELTA-1:0] d;
		d = '0;
		if (c == CH_N || e == CH_N || t == CH_N) begin
			if (e == CH_N)
				d[D_INIT_N] = 1'b1;
			else if (c == CH_N && t != CH_N)
				d[D_NEW_N] = 1'b1;
		end else if (e != t) begin
			d[D_INIT_ERR] = 1'b1;
			if (c == t) begin
				d[D_TP] = 1'b1;
			end else begin
				d[D_FN] = 1'b1;
				d[D_REM_ERR] = 1'b1;
			end
		end else begin
			if (c == t) begin
				d[D_TN] = 1'b1;
			end else begin
				d[D_FP] = 1'b1;
				d[D_REM_ERR] = 1'b1;
			end
		end
		return d;
	endfunction

	// saturating a + b where b is one bit
	function automatic logic [READ_W-1:0] sat_bit(logic [READ_W-1:0] a, logic b);
		logic [READ_W:0] s;
		s = {1'b0, a} + (READ_W + 1)'(b);
		return s[READ_W] ? READ_MAX : s[READ_W-1:0];
	endfunction

	// saturating a + p + b where b is one bit
	function automatic logic [READ_W-1:0] sat_three(logic [READ_W-1:0] a,
			logic [READ_W-1:0] p, logic b);
		logic [READ_W+1:0] s;
		s = (READ_W + 2)'(a) + (READ_W + 2)'(p) + (READ_W + 2)'(b);
		return (s > (READ_W + 2)'(READ_MAX)) ? READ_MAX : s[READ_W-1:0];
	endfunction

	assign in_ready = !q_full;
	assign push = in_valid && !q_full;

	// classification and next per-read state
	always_comb begin
		delta = classify(corrected_base, erroneous_base, true_base);
		gap = (corrected_base == CH_GAP) || (erroneous_base == CH_GAP) ||
			(true_base == CH_GAP);
		pend_n = pend_q;
		err_upd = err_q;
		started_n = started_q;
		cmd = '0;
		if (no_column) begin
			// empty read: nothing added
		end else if (gap) begin
			if (started_q) begin
				for (int k = 0; k < NUM_DELTA; k++)
					pend_n[k] = sat_bit(pend_q[k], delta[k]);
			end
		end else begin
			for (int k = 0; k < NUM_INC; k++)
				cmd.inc[k] = {1'b0, pend_q[k]} + (READ_W + 1)'(delta[k]);
			err_upd[0] = sat_three(err_q[0], pend_q[D_INIT_ERR], delta[D_INIT_ERR]);
			err_upd[1] = sat_three(err_q[1], pend_q[D_REM_ERR], delta[D_REM_ERR]);
			pend_n = '0;
			started_n = 1'b1;
		end
		close = no_column || last_column;
		cmd.close = close;
		cmd.aligned = read_aligned;
		cmd.init_err = err_upd[0];
		cmd.rem_zero = (err_upd[1] == '0);
		err_n = err_upd;
		if (close) begin
			pend_n = '0;
			err_n = '0;
			started_n = 1'b0;
		end
	end

	// per-read state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			err_q <= '0;
			started_q <= 1'b0;
		end else if (push) begin
			pend_q <= pend_n;
			err_q <= err_n;
			started_q <= started_n;
		end
	end

endmodule

// ----- src/rcsc_queue.sv -----
// rcsc_queue: short command queue between front and back so each side
// stalls on its own; depends on rcsc_pkg
module rcsc_queue import rcsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic valid
);

	cmd_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign valid = (count_q != '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");
`endif

endmodule

// ----- src/rcsc_back.sv -----
// rcsc_back: applies classified words to the saturating totals and holds the
// result word for the output stream; depends on rcsc_pkg
module rcsc_back import rcsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  cmd_t             cmd,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	logic [3:0][TOTAL_W-1:0] base_q, base_n;
	logic [1:0][TOTAL_W-1:0] ntot_q, ntot_n;
	logic [3:0][TOTAL_W-1:0] full_q, full_n;
	logic [TOTAL_W-1:0] reads_q, reads_n;
	logic [READ_W-1:0] worst_q, worst_n;
	logic [1:0] full_idx;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [OUT_W-1:0] snap;

	function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] a,
			logic [READ_W:0] b);
		logic [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		return (s > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] a);
		return (a == TOTAL_MAX) ? a : a + 1'b1;
	endfunction

	function automatic logic [31:0] clamp32(logic [TOTAL_W-1:0] v);
		logic [TOTAL_W+31:0] w;
		w = (TOTAL_W + 32)'(v);
		return (w > (TOTAL_W + 32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	function automatic logic [15:0] clamp16(logic [READ_W-1:0] v);
		logic [READ_W+15:0] w;
		w = (READ_W + 16)'(v);
		return (w > (READ_W + 16)'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	// a closing word waits only for the output register
	assign pop = q_valid && (!cmd.close || !m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	// whole-read recovery class
	always_comb begin
		if (!cmd.aligned)
			full_idx = FULL_FN;
		else if (!cmd.rem_zero)
			full_idx = (cmd.init_err == '0) ? FULL_FP : FULL_FN;
		else
			full_idx = (cmd.init_err != '0) ? FULL_TP : FULL_TN;
	end

	// next totals
	always_comb begin
		for (int k = 0; k < 4; k++)
			base_n[k] = sat_add(base_q[k], cmd.inc[k]);
		ntot_n[0] = sat_add(ntot_q[0], cmd.inc[D_INIT_N]);
		ntot_n[1] = sat_add(ntot_q[1], cmd.inc[D_NEW_N]);
		reads_n = reads_q;
		worst_n = worst_q;
		full_n = full_q;
		if (cmd.close) begin
			reads_n = sat_inc(reads_q);
			worst_n = (cmd.init_err > worst_q) ? cmd.init_err : worst_q;
			full_n[full_idx] = sat_inc(full_q[full_idx]);
		end
		snap = {clamp32(full_n[FULL_FN]), clamp32(full_n[FULL_FP]),
			clamp32(full_n[FULL_TN]), clamp32(full_n[FULL_TP]), clamp16(worst_n),
			clamp32(ntot_n[1]), clamp32(ntot_n[0]), clamp32(reads_n),
			clamp32(base_n[D_FN]), clamp32(base_n[D_FP]), clamp32(base_n[D_TN]),
			clamp32(base_n[D_TP])};
	end

	// totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			ntot_q <= '0;
			full_q <= '0;
			reads_q <= '0;
			worst_q <= '0;
		end else if (pop) begin
			base_q <= base_n;
			ntot_q <= ntot_n;
			full_q <= full_n;
			reads_q <= reads_n;
			worst_q <= worst_n;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (pop && cmd.close) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.close)
			m_tdata_q <= snap;
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !(pop && cmd.close))
		else $error("result word overwritten while stalled");
	a_reads_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cmd.close && reads_q != TOTAL_MAX) |=> reads_q == $past(reads_q) + 1'b1)
		else $error("read count missed a closed read");
	a_reads_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cmd.close) |=> $stable(reads_q))
		else $error("read count moved without a closed read");
	a_worst_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> worst_q >= $past(worst_q))
		else $error("worst read errors decreased");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for read_correction_score_counter; streams aligned
// base columns, predicts the twelve totals per closed read and checks each word
// depends on rcsc_pkg and the read_correction_score_counter rtl
module tb_top;
	import rcsc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int TARGET_WORDS = 1750;
	localparam logic [7:0] B_A = "A";
	localparam logic [7:0] B_C = "C";
	localparam logic [7:0] B_G = "G";
	localparam logic [7:0] B_T = "T";

	// running totals of the scorer and the result words they imply
	class score_board;
		localparam longint unsigned TOTAL_TOP = (64'd1 << TOTAL_W) - 1;
		localparam longint unsigned READ_TOP = (64'd1 << READ_W) - 1;

		longint unsigned base_tot[4];
		longint unsigned full_tot[4];
		longint unsigned n_tot[2];
		longint unsigned reads_done;
		longint unsigned worst_err;
		longint unsigned err_cnt[2];
		longint unsigned gap_held[NUM_DELTA];
		bit started;
		logic [OUT_W-1:0] totals_q[$];
		int errors;
		string field_name[12];

		function new();
			field_name = '{"total_tp", "total_tn", "total_fp", "total_fn", "compared_reads",
				"initial_n_count", "new_n_count", "max_read_errors", "full_tp", "full_tn",
				"full_fp", "full_fn"};
		endfunction

		function longint unsigned sat_add(longint unsigned a, longint unsigned b,
			longint unsigned top);
			if (a >= top || b >= top - a)
				return top;
			return a + b;
		endfunction

		function logic [31:0] out32(longint unsigned v);
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function logic [15:0] out16(longint unsigned v);
			return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
		endfunction

		function int pending();
			return totals_q.size();
		endfunction

		// per-column deltas; any N steers the column to the N counts only
		function void classify(logic [7:0] c, logic [7:0] e, logic [7:0] t,
			output longint unsigned d[NUM_DELTA]);
			d = '{default: 0};
			if (c == CH_N || e == CH_N || t == CH_N) begin
				if (e == CH_N)
					d[D_INIT_N] = 1;
				else if (c == CH_N && t != CH_N)
					d[D_NEW_N] = 1;
			end else if (e != t) begin
				d[D_INIT_ERR] = 1;
				if (c == t) begin
					d[D_TP] = 1;
				end else begin
					d[D_FN] = 1;
					d[D_REM_ERR] = 1;
				end
			end else if (c == t) begin
				d[D_TN] = 1;
			end else begin
				d[D_FP] = 1;
				d[D_REM_ERR] = 1;
			end
		endfunction

		function void apply_delta(longint unsigned d[NUM_DELTA]);
			int k;
			for (k = D_TP; k <= D_FN; k++)
				base_tot[k] = sat_add(base_tot[k], d[k], TOTAL_TOP);
			n_tot[0] = sat_add(n_tot[0], d[D_INIT_N], TOTAL_TOP);
			n_tot[1] = sat_add(n_tot[1], d[D_NEW_N], TOTAL_TOP);
			err_cnt[0] = sat_add(err_cnt[0], d[D_INIT_ERR], READ_TOP);
			err_cnt[1] = sat_add(err_cnt[1], d[D_REM_ERR], READ_TOP);
		endfunction

		// end of read: count it, classify recovery, queue the totals word
		function void close_read(logic aligned);
			logic [1:0] cls;
			logic [OUT_W-1:0] totals_word;
			reads_done = sat_add(reads_done, 1, TOTAL_TOP);
			if (err_cnt[0] > worst_err)
				worst_err = err_cnt[0];
			if (!aligned)
				cls = FULL_FN;
			else if (err_cnt[1] != 0)
				cls = (err_cnt[0] == 0) ? FULL_FP : FULL_FN;
			else
				cls = (err_cnt[0] > 0) ? FULL_TP : FULL_TN;
			full_tot[cls] = sat_add(full_tot[cls], 1, TOTAL_TOP);
			started = 0;
			err_cnt = '{default: 0};
			gap_held = '{default: 0};
			totals_word = {out32(full_tot[FULL_FN]), out32(full_tot[FULL_FP]),
				out32(full_tot[FULL_TN]), out32(full_tot[FULL_TP]), out16(worst_err),
				out32(n_tot[1]), out32(n_tot[0]), out32(reads_done), out32(base_tot[D_FN]),
				out32(base_tot[D_FP]), out32(base_tot[D_TN]), out32(base_tot[D_TP])};
			totals_q.insert(totals_q.size(), totals_word);
		endfunction

		// accepted input word
		function void note_column(logic [7:0] c, logic [7:0] e, logic [7:0] t,
			logic no_col, logic last, logic aligned);
			longint unsigned d[NUM_DELTA];
			int k;
			if (no_col) begin
				close_read(aligned);
				return;
			end
			classify(c, e, t, d);
			if (c == CH_GAP || e == CH_GAP || t == CH_GAP) begin
				// leading gaps vanish, later ones wait for a non-gap column
				if (started)
					for (k = 0; k < NUM_DELTA; k++)
						gap_held[k] = sat_add(gap_held[k], d[k], READ_TOP);
			end else begin
				apply_delta(gap_held);
				gap_held = '{default: 0};
				apply_delta(d);
				started = 1;
			end
			if (last)
				close_read(aligned);
		endfunction

		// accepted result word against the oldest prediction
		function void check_totals(logic [OUT_W-1:0] got);
			logic [OUT_W-1:0] want;
			logic [63:0] gv;
			logic [63:0] wv;
			int i;
			int off;
			int w;
			if (totals_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected totals word, expected none, got %h", $time, got);
				return;
			end
			want = totals_q.pop_front();
			off = 0;
			for (i = 0; i < 12; i++) begin
				w = (i == 7) ? READ_W : 32;
				gv = 64'(got >> off) & ((64'd1 << w) - 1);
				wv = 64'(want >> off) & ((64'd1 << w) - 1);
				if (gv !== wv) begin
					errors++;
					$display("%0t: %s expected %0d got %0d", $time, field_name[i], wv, gv);
				end
				off += w;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	score_board sb = new();
	int words_sent;
	int idle_cycles;
	bit snd_calm;
	bit burst;
	bit hold_off_req;

	read_correction_score_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 0;
	always #1 clk = ~clk;

	// monitor both sides and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_totals(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_column(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tuser, s_tlast,
					s_tdata[24]);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// result side: random stalls, calm stretches, one long hold-off
	initial begin
		int gap;
		bit rcv_calm;
		m_tready = 0;
		rcv_calm = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				m_tready <= 0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 0;
			end
			if ($urandom_range(0, 47) == 0)
				rcv_calm = !rcv_calm;
			gap = rcv_calm ? 0 : $urandom_range(0, 12);
			if (gap != 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!(m_tvalid && m_tready))
				@(posedge clk);
		end
	end

	// one input word; returns at the edge that accepts it
	task automatic send_word(logic [7:0] c, logic [7:0] e, logic [7:0] t, logic no_col,
		logic last, logic aligned);
		int gap;
		if (!burst && $urandom_range(0, 47) == 0)
			snd_calm = !snd_calm;
		gap = snd_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {7'b0, aligned, t, e, c};
		s_tuser <= no_col;
		s_tlast <= last;
		s_tvalid <= 1;
		@(posedge clk);
		while (!(s_tvalid && s_tready))
			@(posedge clk);
		words_sent++;
	endtask

	// stop offering until every predicted word has come back
	task automatic drain_results();
		s_tvalid <= 0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] rand_base();
		case ($urandom_range(0, 3))
			0: return B_A;
			1: return B_C;
			2: return B_G;
			default: return B_T;
		endcase
	endfunction

	// occasional N, gap or arbitrary byte
	function automatic logic [7:0] rough(logic [7:0] b);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return CH_N;
		if (r < 8)
			return CH_GAP;
		if (r < 11)
			return 8'($urandom);
		return b;
	endfunction

	task automatic send_column(logic last, logic aligned);
		logic [7:0] c;
		logic [7:0] e;
		logic [7:0] t;
		t = rand_base();
		e = ($urandom_range(0, 99) < 20) ? rand_base() : t;
		if (e != t)
			c = ($urandom_range(0, 99) < 65) ? t : rand_base();
		else
			c = ($urandom_range(0, 99) < 88) ? t : rand_base();
		send_word(rough(c), rough(e), rough(t), 1'b0, last, aligned);
	endtask

	task automatic send_gap_column();
		logic [7:0] b[3];
		b = '{rand_base(), rand_base(), rand_base()};
		b[$urandom_range(0, 2)] = CH_GAP;
		send_word(b[0], b[1], b[2], 1'b0, 1'b0, 1'($urandom));
	endtask

	// one random read: mostly well formed, some empty or cut short
	task automatic send_read();
		int len;
		int lead;
		int cut;
		int k;
		bit al;
		if ($urandom_range(0, 99) < 4) begin
			send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'($urandom),
				1'($urandom));
			return;
		end
		lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
		cut = ($urandom_range(0, 99) < 3) ? $urandom_range(0, len - 1) : -1;
		al = ($urandom_range(0, 9) != 0);
		for (k = 0; k < lead; k++)
			send_gap_column();
		for (k = 0; k < len; k++) begin
			if (k == cut) begin
				send_word(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, al);
				return;
			end
			send_column(k == len - 1, (k == len - 1) ? al : 1'($urandom));
		end
	endtask

	// reset, directed reads, random reads, then drain and report
	initial begin
		int next_pause;
		bit burst_done;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = 0;
		s_tlast = 0;
		words_sent = 0;
		idle_cycles = 0;
		snd_calm = 0;
		burst = 0;
		hold_off_req = 0;
		burst_done = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty reads: aligned with last set too, then unaligned
		send_word(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1);
		send_word(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
		// leading gap, every score kind, N cases, gaps held then committed
		send_word(CH_GAP, B_A, B_A, 1'b0, 1'b0, 1'b1);
		send_word(B_A, B_C, B_A, 1'b0, 1'b0, 1'b0);
		send_word(B_A, B_A, B_A, 1'b0, 1'b0, 1'b1);
		send_word(B_G, B_A, B_A, 1'b0, 1'b0, 1'b0);
		send_word(B_G, B_C, B_A, 1'b0, 1'b0, 1'b1);
		send_word(B_A, CH_N, B_A, 1'b0, 1'b0, 1'b0);
		send_word(CH_N, B_A, B_A, 1'b0, 1'b0, 1'b1);
		send_word(CH_N, B_A, CH_N, 1'b0, 1'b0, 1'b0);
		send_word(B_A, CH_GAP, B_A, 1'b0, 1'b0, 1'b1);
		send_word(B_C, B_A, B_C, 1'b0, 1'b0, 1'b0);
		send_word(B_A, B_C, CH_GAP, 1'b0, 1'b0, 1'b1);
		send_word(B_T, B_T, B_T, 1'b0, 1'b1, 1'b1);
		// whole-read classes: recovered, made wrong, unaligned clean
		send_word(B_A, B_C, B_A, 1'b0, 1'b1, 1'b1);
		send_word(B_G, B_A, B_A, 1'b0, 1'b1, 1'b1);
		send_word(B_A, B_A, B_A, 1'b0, 1'b1, 1'b0);
		// byte extremes, then a gap on the last column
		send_word(8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);
		send_word(8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1);
		send_word(B_C, B_C, CH_GAP, 1'b0, 1'b1, 1'b1);
		// read of gaps only
		send_word(CH_GAP, CH_GAP, CH_GAP, 1'b0, 1'b1, 1'b1);
		// held gap dropped by an empty-read close
		send_word(B_A, B_A, B_A, 1'b0, 1'b0, 1'b0);
		send_word(B_C, CH_GAP, B_G, 1'b0, 1'b0, 1'b1);
		send_word(B_A, B_A, B_A, 1'b1, 1'b0, 1'b1);
		drain_results();

		next_pause = words_sent + 450;
		while (words_sent < TARGET_WORDS) begin
			send_read();
			if (!burst_done && words_sent > TARGET_WORDS / 2) begin
				// hold off the result side while short reads keep coming
				burst_done = 1;
				drain_results();
				burst = 1;
				snd_calm = 1;
				hold_off_req = 1;
				repeat (40)
					send_word(B_A, B_C, B_A, 1'b0, 1'b1, 1'b1);
				burst = 0;
				snd_calm = 0;
			end
			if (words_sent >= next_pause) begin
				drain_results();
				next_pause = words_sent + 450;
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
